>>> rtl/core/strict_four_hex_byte_parser_defines.svh
// Assertion macros shared by the parser RTL.
`ifndef STRICT_FOUR_HEX_BYTE_PARSER_DEFINES_SVH
`define STRICT_FOUR_HEX_BYTE_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFHBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfhbp assertion failed");

// Next-cycle implication, checked outside reset.
`define SFHBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfhbp assertion failed");

`endif

>>> rtl/core/sfhbp_pkg.sv
// Types, constants and codes of the strict four hex byte parser.
`timescale 1ns / 1ps
package sfhbp_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned NUM_TOK  = 4;
    localparam int unsigned BYTES_W  = CHAR_W * NUM_TOK;

    localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'h7E;
    localparam logic [CHAR_W-1:0] BYTE_MASK  = 8'hFF;
    localparam logic [2:0]        TOK_TARGET = 3'd4;

    typedef enum logic [2:0] {
        PH_ZERO = 3'd0,
        PH_X    = 3'd1,
        PH_HI   = 3'd2,
        PH_LO   = 3'd3,
        PH_TAIL = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_RANGE  = 2'd2,
        ST_COUNT  = 2'd3
    } t_status;

    typedef struct packed {
        logic       is_term;
        logic       is_zero_digit;
        logic       is_x;
        logic       is_sep;
        logic       is_tail_ok;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_char_class;

    typedef struct packed {
        t_status            status;
        logic [BYTES_W-1:0] bytes;
    } t_result;

endpackage

>>> rtl/core/sfhbp_char_class.sv
// Character classifier: terminator, prefix, separator, whitespace and hex digit decode.
`timescale 1ns / 1ps
module sfhbp_char_class (
    input  logic [sfhbp_pkg::CHAR_W-1:0] i_char,
    output sfhbp_pkg::t_char_class       o_class
);

    logic w_digit;
    logic w_lower;
    logic w_upper;
    logic w_space;
    logic w_sep;

    always_comb begin
        w_digit = (i_char >= 8'h30) && (i_char <= 8'h39);
        w_lower = (i_char >= 8'h61) && (i_char <= 8'h66);
        w_upper = (i_char >= 8'h41) && (i_char <= 8'h46);
        w_space = (i_char == 8'h20) || ((i_char >= 8'h09) && (i_char <= 8'h0D));
        w_sep   = (i_char == 8'h2C) || (i_char == 8'h20) || (i_char == 8'h3B);

        o_class.is_term       = (i_char == 8'h00);
        o_class.is_zero_digit = (i_char == 8'h30);
        o_class.is_x          = (i_char == 8'h78) || (i_char == 8'h58);
        o_class.is_sep        = w_sep;
        o_class.is_tail_ok    = w_space || (i_char == 8'h2C) || (i_char == 8'h3B);
        o_class.is_hex        = w_digit || w_lower || w_upper;
        if (w_digit) begin
            o_class.hex_val = i_char[3:0];
        end else if (w_lower || w_upper) begin
            o_class.hex_val = i_char[3:0] + 4'd9;
        end else begin
            o_class.hex_val = 4'd0;
        end
    end

endmodule

>>> rtl/core/sfhbp_parse_fsm.sv
// Parser state machine: token phases, collected bytes and the fixed verdict.
`timescale 1ns / 1ps
`include "strict_four_hex_byte_parser_defines.svh"
module sfhbp_parse_fsm (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  sfhbp_pkg::t_char_class  i_class,
    output logic                    o_load,
    output sfhbp_pkg::t_result      o_result
);

    sfhbp_pkg::t_phase                r_phase,   n_phase;
    logic [2:0]                       r_tokens,  n_tokens;
    logic [3:0]                       r_upper,   n_upper;
    logic [sfhbp_pkg::BYTES_W-1:0]    r_bytes,   n_bytes;
    sfhbp_pkg::t_status               r_verdict, n_verdict;
    logic                             r_decided, n_decided;

    logic [sfhbp_pkg::CHAR_W-1:0]     w_value;
    logic                             w_printable;

    always_comb begin
        w_value     = {r_upper, i_class.hex_val};
        w_printable = (w_value >= sfhbp_pkg::PRINT_LOW) && (w_value <= sfhbp_pkg::PRINT_HIGH);
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_tokens  = r_tokens;
        n_upper   = r_upper;
        n_bytes   = r_bytes;
        n_verdict = r_verdict;
        n_decided = r_decided;
        if (i_accept) begin
            if (i_class.is_term) begin
                n_phase   = sfhbp_pkg::PH_ZERO;
                n_tokens  = 3'd0;
                n_upper   = 4'd0;
                n_bytes   = '0;
                n_verdict = sfhbp_pkg::ST_OK;
                n_decided = 1'b0;
            end else if (!r_decided) begin
                case (r_phase)
                    sfhbp_pkg::PH_ZERO: begin
                        if ((r_tokens != 3'd0) && i_class.is_sep) begin
                            n_phase = r_phase;
                        end else if (i_class.is_zero_digit) begin
                            n_phase = sfhbp_pkg::PH_X;
                        end else begin
                            n_verdict = sfhbp_pkg::ST_FORMAT;
                            n_decided = 1'b1;
                        end
                    end
                    sfhbp_pkg::PH_X: begin
                        if (i_class.is_x) begin
                            n_phase = sfhbp_pkg::PH_HI;
                        end else begin
                            n_verdict = sfhbp_pkg::ST_FORMAT;
                            n_decided = 1'b1;
                        end
                    end
                    sfhbp_pkg::PH_HI: begin
                        if (i_class.is_hex) begin
                            n_upper = i_class.hex_val;
                            n_phase = sfhbp_pkg::PH_LO;
                        end else begin
                            n_verdict = sfhbp_pkg::ST_FORMAT;
                            n_decided = 1'b1;
                        end
                    end
                    sfhbp_pkg::PH_LO: begin
                        if (!i_class.is_hex) begin
                            n_verdict = sfhbp_pkg::ST_FORMAT;
                            n_decided = 1'b1;
                        end else if (!w_printable) begin
                            n_verdict = sfhbp_pkg::ST_RANGE;
                            n_decided = 1'b1;
                        end else begin
                            n_bytes[{r_tokens[1:0], 3'b000} +: sfhbp_pkg::CHAR_W] =
                                r_bytes[{r_tokens[1:0], 3'b000} +: sfhbp_pkg::CHAR_W] | w_value;
                            n_tokens = r_tokens + 3'd1;
                            n_phase  = (n_tokens >= sfhbp_pkg::TOK_TARGET) ?
                                       sfhbp_pkg::PH_TAIL : sfhbp_pkg::PH_ZERO;
                        end
                    end
                    sfhbp_pkg::PH_TAIL: begin
                        n_verdict = i_class.is_tail_ok ? sfhbp_pkg::ST_OK : sfhbp_pkg::ST_COUNT;
                        n_decided = 1'b1;
                    end
                    default: begin
                        n_verdict = sfhbp_pkg::ST_FORMAT;
                        n_decided = 1'b1;
                    end
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        o_load = i_accept && i_class.is_term;
        if (r_decided) begin
            o_result.status = r_verdict;
        end else if (r_phase == sfhbp_pkg::PH_ZERO) begin
            o_result.status = sfhbp_pkg::ST_COUNT;
        end else if (r_phase == sfhbp_pkg::PH_TAIL) begin
            o_result.status = sfhbp_pkg::ST_OK;
        end else begin
            o_result.status = sfhbp_pkg::ST_FORMAT;
        end
        o_result.bytes = (o_result.status == sfhbp_pkg::ST_OK) ? r_bytes : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sfhbp_pkg::PH_ZERO;
            r_tokens  <= 3'd0;
            r_upper   <= 4'd0;
            r_bytes   <= '0;
            r_verdict <= sfhbp_pkg::ST_OK;
            r_decided <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_tokens  <= n_tokens;
            r_upper   <= n_upper;
            r_bytes   <= n_bytes;
            r_verdict <= n_verdict;
            r_decided <= n_decided;
        end
    end

    `SFHBP_ASSERT_IMPL(a_tail_has_four, i_clk, i_rst_n, r_phase == sfhbp_pkg::PH_TAIL, r_tokens == sfhbp_pkg::TOK_TARGET)
    `SFHBP_ASSERT_IMPL(a_tokens_bounded, i_clk, i_rst_n, 1'b1, r_tokens <= sfhbp_pkg::TOK_TARGET)
    `SFHBP_ASSERT_NEXT(a_term_restarts, i_clk, i_rst_n, o_load, (r_phase == sfhbp_pkg::PH_ZERO) && !r_decided && (r_tokens == 3'd0))

endmodule

>>> rtl/core/sfhbp_out_reg.sv
// Result register on the master side of the parser.
`timescale 1ns / 1ps
`include "strict_four_hex_byte_parser_defines.svh"
module sfhbp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  sfhbp_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_free,
    output sfhbp_pkg::t_result o_result
);

    logic               r_valid, n_valid;
    sfhbp_pkg::t_result r_result, n_result;

    always_comb begin
        o_free   = !r_valid || i_ready;
        n_valid  = i_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);
        n_result = i_load ? i_result : r_result;
        o_valid  = r_valid;
        o_result = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    `SFHBP_ASSERT_IMPL(a_bad_status_zero_bytes, i_clk, i_rst_n, r_valid && (r_result.status != sfhbp_pkg::ST_OK), r_result.bytes == '0)

endmodule

>>> rtl/core/strict_four_hex_byte_parser.sv
// Strict four hex byte parser: one text character per transfer in, one verdict per string out.
//
// Slave channel: one 8-bit character per transfer; the value zero ends the string.
// Master channel: one transfer per string, issued for its terminator. tuser carries the
// status (0 ok, 1 bad prefix or digit, 2 value not printable, 3 too few tokens or extra
// data); tdata carries the four parsed bytes, zero unless the status is ok.
// Characters are taken every cycle unless a result waits on a stalled receiver; a character
// other than the terminator only updates the parser state. The result appears on the master
// side in the cycle after the terminator transfer, held in a single result register.
// Throughput is one character per cycle while no result waits on a stalled receiver.
// While a result waits, slave tready follows master tready: a stalled receiver holds off
// every character, and a result taken in a cycle frees the input in that same cycle.
// Reset clears the parser to expect the first token and empties the result register.
`timescale 1ns / 1ps
module strict_four_hex_byte_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] character
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] byte_zero, [15:8] byte_one,
                                          // [23:16] byte_two, [31:24] byte_three
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    sfhbp_pkg::t_char_class w_class;
    sfhbp_pkg::t_result     w_result;
    sfhbp_pkg::t_result     w_out;
    logic                   w_accept;
    logic                   w_load;
    logic                   w_free;

    assign o_s_axis_tready = w_free;
    assign w_accept        = i_s_axis_tvalid && w_free;

    sfhbp_char_class u_class (
        .i_char  (i_s_axis_tdata),
        .o_class (w_class)
    );

    sfhbp_parse_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_class  (w_class),
        .o_load   (w_load),
        .o_result (w_result)
    );

    sfhbp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_free   (w_free),
        .o_result (w_out)
    );

    assign o_m_axis_tdata = w_out.bytes;
    assign o_m_axis_tuser = w_out.status;

endmodule

>>> test/strict_four_hex_byte_parser_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench of the strict four hex byte parser, with its own parser model.
module strict_four_hex_byte_parser_test;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_CHARS = 530;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIR_ROWS     = 28;

    typedef struct {
        string                text;
        bit                   typed;
        sfhbp_pkg::t_status   status;
        logic [31:0]          bytes;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] character
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [7:0] byte_zero, [15:8] byte_one,
                                   // [23:16] byte_two, [31:24] byte_three
    logic [1:0]  o_m_axis_tuser;   // [1:0] status

    // parser model state
    sfhbp_pkg::t_phase  pm_phase;
    logic [2:0]         pm_tokens;
    logic [3:0]         pm_upper;
    logic [31:0]        pm_bytes;
    sfhbp_pkg::t_status pm_verdict;
    logic               pm_decided;

    sfhbp_pkg::t_result pending_verdicts [$];
    logic [7:0]  text_q [$];
    bit          typed_pending;
    sfhbp_pkg::t_result typed_result;
    bit          sender_gaps     = 1'b1;
    bit          receiver_stalls = 1'b1;
    bit          calm            = 1'b0;
    bit          long_hold_request = 1'b0;
    int          failures        = 0;
    int          results_checked = 0;
    int          chars_sent      = 0;
    int          strings_sent    = 0;
    int          cycle_count     = 0;
    int          status_tally [4] = '{0, 0, 0, 0};

    t_directed_row dir_rows [DIR_ROWS] = '{
        '{"",                          1'b1, sfhbp_pkg::ST_COUNT,  32'h0},
        '{"0x41,0x42;0x43 0x44",       1'b1, sfhbp_pkg::ST_OK,     32'h44434241},
        '{"0X20;; ,0X7e 0x7E , 0x20",  1'b1, sfhbp_pkg::ST_OK,     32'h207E7E20},
        '{"0x6a 0x5B 0x3D 0x5f\011zz", 1'b1, sfhbp_pkg::ST_OK,     32'h5F3D5B6A},
        '{"0x30 0x39 0x61 0x46\012",   1'b0, sfhbp_pkg::ST_OK,     32'h0},
        '{"0x7e 0x7e 0x7e 0x7e\013!",  1'b0, sfhbp_pkg::ST_OK,     32'h0},
        '{"0x21 0x22 0x23 0x24\014",   1'b0, sfhbp_pkg::ST_OK,     32'h0},
        '{"0x2f 0x3a 0x40 0x47\015",   1'b0, sfhbp_pkg::ST_OK,     32'h0},
        '{"0x41 0x42 0x43 0x44;0x1F",  1'b0, sfhbp_pkg::ST_OK,     32'h0},
        '{"0x41 0x42 0x43 0x44",       1'b1, sfhbp_pkg::ST_OK,     32'h44434241},
        '{"0x41 0x42 0x43 0x44x",      1'b1, sfhbp_pkg::ST_COUNT,  32'h0},
        '{"0x41 0x42 0x43 0x44\377",   1'b1, sfhbp_pkg::ST_COUNT,  32'h0},
        '{",0x41",                     1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{" 0x41 0x42 0x43 0x44",      1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"0x41 0x42 0x43",            1'b1, sfhbp_pkg::ST_COUNT,  32'h0},
        '{"0x4",                       1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"0x",                        1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"0",                         1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"0y41",                      1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"1x41",                      1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"0xg1",                      1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"0x4G",                      1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"0x\2004",                   1'b1, sfhbp_pkg::ST_FORMAT, 32'h0},
        '{"0x1F 0x41",                 1'b1, sfhbp_pkg::ST_RANGE,  32'h0},
        '{"0x7F",                      1'b1, sfhbp_pkg::ST_RANGE,  32'h0},
        '{"0xff",                      1'b1, sfhbp_pkg::ST_RANGE,  32'h0},
        '{"0x00",                      1'b1, sfhbp_pkg::ST_RANGE,  32'h0},
        '{"0x41 0x42 0x43 0x44 ;junk", 1'b0, sfhbp_pkg::ST_OK,     32'h0}
    };

    strict_four_hex_byte_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic void clear_parser();
        pm_phase   = sfhbp_pkg::PH_ZERO;
        pm_tokens  = '0;
        pm_upper   = '0;
        pm_bytes   = '0;
        pm_verdict = sfhbp_pkg::ST_OK;
        pm_decided = 1'b0;
    endfunction

    function automatic void settle(input sfhbp_pkg::t_status s);
        pm_verdict = s;
        pm_decided = 1'b1;
    endfunction

    function automatic bit hex_digit(input logic [7:0] ch, output logic [3:0] nib);
        nib = '0;
        if (ch >= "0" && ch <= "9") begin
            nib = 4'(ch - "0");
        end else if (ch >= "a" && ch <= "f") begin
            nib = 4'(ch - "a" + 8'd10);
        end else if (ch >= "A" && ch <= "F") begin
            nib = 4'(ch - "A" + 8'd10);
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return "0" + 8'(nib);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10;
    endfunction

    // advance the parser model by one character; returns 1 on a terminator, with its verdict in res
    function automatic bit parse_char(input logic [7:0] ch, output sfhbp_pkg::t_result res);
        logic [3:0] nib;
        logic [7:0] value;
        res.status = sfhbp_pkg::ST_OK;
        res.bytes  = '0;
        if (ch == 8'h00) begin
            if (pm_decided)                          res.status = pm_verdict;
            else if (pm_phase == sfhbp_pkg::PH_ZERO) res.status = sfhbp_pkg::ST_COUNT;
            else if (pm_phase == sfhbp_pkg::PH_TAIL) res.status = sfhbp_pkg::ST_OK;
            else                                     res.status = sfhbp_pkg::ST_FORMAT;
            if (res.status == sfhbp_pkg::ST_OK) res.bytes = pm_bytes;
            clear_parser();
            return 1'b1;
        end
        if (pm_decided) return 1'b0;
        case (pm_phase)
            sfhbp_pkg::PH_ZERO: begin
                if (!(pm_tokens != 0 && (ch == "," || ch == " " || ch == ";"))) begin
                    if (ch == "0") pm_phase = sfhbp_pkg::PH_X;
                    else           settle(sfhbp_pkg::ST_FORMAT);
                end
            end
            sfhbp_pkg::PH_X: begin
                if (ch == "x" || ch == "X") pm_phase = sfhbp_pkg::PH_HI;
                else                        settle(sfhbp_pkg::ST_FORMAT);
            end
            sfhbp_pkg::PH_HI: begin
                if (hex_digit(ch, nib)) begin
                    pm_upper = nib;
                    pm_phase = sfhbp_pkg::PH_LO;
                end else begin
                    settle(sfhbp_pkg::ST_FORMAT);
                end
            end
            sfhbp_pkg::PH_LO: begin
                if (!hex_digit(ch, nib)) begin
                    settle(sfhbp_pkg::ST_FORMAT);
                end else begin
                    value = {pm_upper, nib};
                    if (value < sfhbp_pkg::PRINT_LOW || value > sfhbp_pkg::PRINT_HIGH) begin
                        settle(sfhbp_pkg::ST_RANGE);
                    end else begin
                        pm_bytes[pm_tokens[1:0]*8 +: 8] = value;
                        pm_tokens = pm_tokens + 3'd1;
                        pm_phase  = (pm_tokens >= sfhbp_pkg::TOK_TARGET) ?
                                    sfhbp_pkg::PH_TAIL : sfhbp_pkg::PH_ZERO;
                    end
                end
            end
            sfhbp_pkg::PH_TAIL: begin
                if ((ch >= 8'h09 && ch <= 8'h0D) || ch == " " || ch == "," || ch == ";")
                    settle(sfhbp_pkg::ST_OK);
                else
                    settle(sfhbp_pkg::ST_COUNT);
            end
            default: settle(sfhbp_pkg::ST_FORMAT);
        endcase
        return 1'b0;
    endfunction

    task automatic send_char(input logic [7:0] ch);
        sfhbp_pkg::t_result res;
        if (!calm && sender_gaps && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
        chars_sent++;
        if (parse_char(ch, res)) begin
            if (typed_pending) begin
                res = typed_result;
                typed_pending = 1'b0;
            end
            status_tally[res.status]++;
            pending_verdicts.push_back(res);
        end
    endtask

    // mostly well-formed four-token strings, some corrupted, truncated or pure noise
    task automatic build_random_string();
        string      separators = ", ;";
        string      tails = " \011\012\013\014\015,;";
        int         mode;
        logic [7:0] value;
        text_q.delete();
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(1, 255)));
            return;
        end
        if (mode == 3) text_q.push_back(separators[$urandom_range(0, 2)]);
        for (int t = 0; t < sfhbp_pkg::NUM_TOK; t++) begin
            if (t > 0)
                repeat ($urandom_range(0, 3)) text_q.push_back(separators[$urandom_range(0, 2)]);
            text_q.push_back("0");
            text_q.push_back($urandom_range(0, 1) ? "x" : "X");
            value = ($urandom_range(0, 7) == 0) ?
                    8'($urandom) :
                    8'($urandom_range(sfhbp_pkg::PRINT_LOW, sfhbp_pkg::PRINT_HIGH));
            text_q.push_back(hex_char(value[7:4]));
            text_q.push_back(hex_char(value[3:0]));
        end
        case ($urandom_range(0, 3))
            0: ;
            1: text_q.push_back(tails[$urandom_range(0, 7)]);
            2: text_q.push_back(8'($urandom_range(1, 255)));
            default: begin
                text_q.push_back(tails[$urandom_range(0, 7)]);
                repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
            end
        endcase
        if (mode == 1) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
        if (mode == 2) repeat ($urandom_range(1, text_q.size())) void'(text_q.pop_back());
    endtask

    always @(posedge i_clk) begin
        sfhbp_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, status %0d bytes %h",
                         $time, o_m_axis_tuser, o_m_axis_tdata);
                failures++;
            end else begin
                want = pending_verdicts.pop_front();
                results_checked++;
                if (o_m_axis_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, o_m_axis_tuser);
                    failures++;
                end
                if (o_m_axis_tdata !== want.bytes) begin
                    $display("%0t: bytes mismatch, expected %h actual %h",
                             $time, want.bytes, o_m_axis_tdata);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_verdicts.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin : receiver
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) receiver_stalls = !receiver_stalls;
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                i_m_axis_tready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) @(posedge i_clk);
            end else if (!calm && receiver_stalls && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        int random_chars;
        bit hold_done;
        bit pause_done;
        random_chars = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        clear_parser();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int i = 0; i < dir_rows[r].text.len(); i++) send_char(dir_rows[r].text[i]);
            typed_pending       = dir_rows[r].typed;
            typed_result.status = dir_rows[r].status;
            typed_result.bytes  = dir_rows[r].bytes;
            send_char(8'h00);
            strings_sent++;
        end

        while (random_chars < RANDOM_CHARS) begin
            if (!hold_done && random_chars >= RANDOM_CHARS / 3) begin
                long_hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && random_chars >= 2 * RANDOM_CHARS / 3) begin
                i_s_axis_tvalid <= 1'b0;
                while (pending_verdicts.size() != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end
            if (random_chars >= RANDOM_CHARS * 85 / 100) calm = 1'b1;
            sender_gaps = ($urandom_range(0, 3) != 0);
            build_random_string();
            foreach (text_q[i]) send_char(text_q[i]);
            send_char(8'h00);
            strings_sent++;
            random_chars += text_q.size() + 1;
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d strings in %0d characters, %0d verdicts checked",
                 strings_sent, chars_sent, results_checked);
        $display("verdicts: ok %0d, bad prefix or digit %0d, not printable %0d, count %0d",
                 status_tally[sfhbp_pkg::ST_OK], status_tally[sfhbp_pkg::ST_FORMAT],
                 status_tally[sfhbp_pkg::ST_RANGE], status_tally[sfhbp_pkg::ST_COUNT]);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
